FILE: hw/rtl/stq_pkg.sv
// shared types and constants of the sorted timer queue
`timescale 1ns / 1ps
package stq_pkg;

  localparam int NumTimers  = 16;
  localparam int UptimeBits = 32;
  localparam int IdW        = $clog2(NumTimers);

  // fixed widths of the channel fields
  localparam int CmdW      = 2;
  localparam int TimerIdW  = 4;
  localparam int ExpiresW  = 32;
  localparam int UptimeOutW = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK    = 2'd0,
    CMD_ARM     = 2'd1,
    CMD_DISARM  = 2'd2,
    CMD_PROCESS = 2'd3
  } stq_cmd_e;

  // operation applied to every cell of a chain in the same cycle
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_REMOVE,
    OP_INSERT,
    OP_APPEND,
    OP_POP_TAIL,
    OP_POP_HEAD
  } stq_op_e;

  typedef struct packed {
    logic                  valid;
    logic [IdW-1:0]        id;
    logic [UptimeBits-1:0] expiry;
  } stq_entry_t;

  typedef struct packed {
    stq_op_e        op;
    logic [IdW-1:0] id;
    stq_entry_t     ins;
  } stq_ctrl_t;

endpackage

FILE: hw/rtl/stq_if.sv
// command and result channel interfaces of the sorted timer queue
`timescale 1ns / 1ps
interface stq_cmd_if;
  import stq_pkg::*;

  logic                valid;
  logic                ready;
  logic [CmdW-1:0]     command;
  logic [TimerIdW-1:0] timer_id;
  logic [ExpiresW-1:0] expires;

  modport source (output valid, command, timer_id, expires, input ready);
  modport sink   (input valid, command, timer_id, expires, output ready);
endinterface

interface stq_res_if;
  import stq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  fired_valid;
  logic [TimerIdW-1:0]   fired_timer;
  logic                  last;
  logic [UptimeOutW-1:0] uptime;

  modport source (output valid, fired_valid, fired_timer, last, uptime, input ready);
  modport sink   (input valid, fired_valid, fired_timer, last, uptime, output ready);
endinterface

FILE: hw/rtl/stq_cell.sv
// one list cell: holds a slot entry and trades it with its neighbors
`timescale 1ns / 1ps
module stq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stq_pkg::stq_ctrl_t  ctrl_i,
  input  stq_pkg::stq_entry_t left_i,
  input  logic               left_ge_i,
  input  stq_pkg::stq_entry_t right_i,
  input  logic               rm_prefix_i,
  output stq_pkg::stq_entry_t entry_o,
  output logic               ge_o,
  output logic               rm_prefix_o
);
  import stq_pkg::*;

  logic                  valid_q, valid_d;
  logic [IdW-1:0]        id_q, id_d;
  logic [UptimeBits-1:0] exp_q, exp_d;
  logic                  shift_in;

  assign entry_o = '{valid: valid_q, id: id_q, expiry: exp_q};

  // this cell and all after it move for a sorted insert
  assign ge_o = valid_q && (exp_q >= ctrl_i.ins.expiry);
  // removal closes the gap from the matching cell onward
  assign rm_prefix_o = rm_prefix_i || (valid_q && (id_q == ctrl_i.id));
  assign shift_in = valid_q ? ge_o : left_i.valid;

  // next entry for the broadcast operation
  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    exp_d   = exp_q;
    unique case (ctrl_i.op)
      OP_REMOVE: begin
        if (rm_prefix_o) begin
          valid_d = right_i.valid;
          id_d    = right_i.id;
          exp_d   = right_i.expiry;
        end
      end
      OP_INSERT: begin
        if (shift_in) begin
          if (left_ge_i) begin
            valid_d = left_i.valid;
            id_d    = left_i.id;
            exp_d   = left_i.expiry;
          end else begin
            valid_d = 1'b1;
            id_d    = ctrl_i.ins.id;
            exp_d   = ctrl_i.ins.expiry;
          end
        end
      end
      OP_APPEND: begin
        if (!valid_q && left_i.valid) begin
          valid_d = 1'b1;
          id_d    = ctrl_i.ins.id;
          exp_d   = ctrl_i.ins.expiry;
        end
      end
      OP_POP_TAIL: begin
        if (valid_q && !right_i.valid) begin
          valid_d = 1'b0;
        end
      end
      OP_POP_HEAD: begin
        valid_d = right_i.valid;
        id_d    = right_i.id;
        exp_d   = right_i.expiry;
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  // occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // slot and expiry payload
  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    exp_q <= exp_d;
  end

endmodule

FILE: hw/rtl/stq_chain.sv
// row of list cells with head, second and tail taps
`timescale 1ns / 1ps
module stq_chain (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stq_pkg::stq_ctrl_t  ctrl_i,
  output stq_pkg::stq_entry_t head_o,
  output stq_pkg::stq_entry_t second_o,
  output stq_pkg::stq_entry_t tail_o
);
  import stq_pkg::*;

  stq_entry_t           cell_q [NumTimers];
  logic [NumTimers-1:0] ge;
  logic [NumTimers-1:0] rmp;
  logic [NumTimers-1:0] valid_vec;
  logic [NumTimers-1:0] tail_sel;

  for (genvar i = 0; i < NumTimers; i++) begin : g_cell
    stq_entry_t left_e;
    stq_entry_t right_e;
    logic       left_ge;
    logic       rm_in;

    // list edges: the head sees a full neighbor, the end sees an empty one
    if (i == 0) begin : g_first
      assign left_e  = '{valid: 1'b1, id: '0, expiry: '0};
      assign left_ge = 1'b0;
      assign rm_in   = 1'b0;
    end else begin : g_inner
      assign left_e  = cell_q[i-1];
      assign left_ge = ge[i-1];
      assign rm_in   = rmp[i-1];
    end
    if (i == NumTimers - 1) begin : g_end
      assign right_e = '0;
    end else begin : g_next
      assign right_e = cell_q[i+1];
    end

    stq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl_i),
      .left_i      (left_e),
      .left_ge_i   (left_ge),
      .right_i     (right_e),
      .rm_prefix_i (rm_in),
      .entry_o     (cell_q[i]),
      .ge_o        (ge[i]),
      .rm_prefix_o (rmp[i])
    );

    assign valid_vec[i] = cell_q[i].valid;
  end

  assign head_o   = cell_q[0];
  assign second_o = cell_q[1];

  // last occupied cell: the newest entry of a list kept in arm order
  assign tail_sel = valid_vec & ~(valid_vec >> 1);

  always_comb begin
    tail_o = '0;
    for (int i = 0; i < NumTimers; i++) begin
      tail_o = tail_o | (cell_q[i] & {$bits(stq_entry_t){tail_sel[i]}});
    end
  end

endmodule

FILE: hw/rtl/sorted_timer_queue_core.sv
// top level of the sorted timer queue: sequencer, pending and armed lists
//
// Usage: commands enter on cmd_i (tick, arm, disarm, process) and every
// command yields one or more words on res_o. Tick, arm and disarm give one
// word with fired_valid low and last high. Process merges the pending
// slots into the expiry-sorted armed list, then gives one word per expired
// slot in firing order, last on the final one, or a single empty word.
// Sequence: a command is taken in the idle state; a tick ends in S_EXEC,
// disarm passes S_EXEC, S_DONE and arm S_EXEC, S_APPEND, S_DONE. Process
// passes S_EXEC, S_MERGE (one pending slot per step) and S_FIRE, then
// S_DONE for the empty word; a second process in the same tick passes
// S_EXEC, S_DONE. Each step is one broadcast operation on NumTimers cells.
// The uptime field carries the tick count after the command.
// Reset clears both lists, the tick count and the processed flag at once.
// A stalled receiver holds the result register; the next command is still
// taken, and the sequencer waits only when it has a new word to write.
`timescale 1ns / 1ps
module sorted_timer_queue_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  stq_cmd_if.sink   cmd_i,
  stq_res_if.source res_o
);
  import stq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_APPEND,
    S_DONE,
    S_MERGE,
    S_FIRE
  } state_e;

  state_e                state_q;
  stq_cmd_e              cmd_q;
  logic [TimerIdW-1:0]   tid_q;
  logic [UptimeBits-1:0] exp_q;
  logic [UptimeBits-1:0] tick_q;
  logic                  processed_q;

  logic                  res_valid_q;
  logic                  res_fired_q;
  logic [TimerIdW-1:0]   res_timer_q;
  logic                  res_last_q;
  logic [UptimeOutW-1:0] res_uptime_q;

  stq_ctrl_t             pend_ctrl;
  stq_ctrl_t             arm_ctrl;
  stq_entry_t            pend_head;
  stq_entry_t            pend_second;
  stq_entry_t            pend_tail;
  stq_entry_t            arm_head;
  stq_entry_t            arm_second;
  stq_entry_t            arm_tail;

  logic                  out_free;
  logic                  in_range;
  logic                  head_fires;
  logic                  second_fires;
  logic                  res_load;
  logic [UptimeBits-1:0] tick_inc;

  assign out_free     = !res_valid_q || res_o.ready;
  assign in_range     = 32'(tid_q) < NumTimers;
  assign head_fires   = arm_head.valid && (arm_head.expiry <= tick_q);
  assign second_fires = arm_second.valid && (arm_second.expiry <= tick_q);
  assign tick_inc     = tick_q + 1'b1;

  // a new word is written into the result register this cycle
  assign res_load = out_free && (((state_q == S_EXEC) && (cmd_q == CMD_TICK)) ||
                                 ((state_q == S_FIRE) && head_fires) ||
                                 (state_q == S_DONE));

  assign cmd_i.ready       = (state_q == S_IDLE);
  assign res_o.valid       = res_valid_q;
  assign res_o.fired_valid = res_fired_q;
  assign res_o.fired_timer = res_timer_q;
  assign res_o.last        = res_last_q;
  assign res_o.uptime      = res_uptime_q;

  // list operations for the current step
  always_comb begin
    pend_ctrl.op  = OP_HOLD;
    pend_ctrl.id  = IdW'(tid_q);
    pend_ctrl.ins = '{valid: 1'b1, id: IdW'(tid_q), expiry: exp_q};
    arm_ctrl.op   = OP_HOLD;
    arm_ctrl.id   = IdW'(tid_q);
    arm_ctrl.ins  = pend_tail;
    unique case (state_q)
      S_EXEC: begin
        if ((cmd_q == CMD_ARM || cmd_q == CMD_DISARM) && in_range) begin
          pend_ctrl.op = OP_REMOVE;
          arm_ctrl.op  = OP_REMOVE;
        end
      end
      S_APPEND: begin
        pend_ctrl.op = OP_APPEND;
      end
      S_MERGE: begin
        if (pend_tail.valid) begin
          pend_ctrl.op = OP_POP_TAIL;
          arm_ctrl.op  = OP_INSERT;
        end
      end
      S_FIRE: begin
        if (head_fires && out_free) begin
          arm_ctrl.op = OP_POP_HEAD;
        end
      end
      default: begin
        pend_ctrl.op = OP_HOLD;
      end
    endcase
  end

  // sequencer, tick count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= CMD_TICK;
      tid_q        <= '0;
      exp_q        <= '0;
      tick_q       <= '0;
      processed_q  <= 1'b0;
      res_valid_q  <= 1'b0;
      res_fired_q  <= 1'b0;
      res_timer_q  <= '0;
      res_last_q   <= 1'b0;
      res_uptime_q <= '0;
    end else begin
      if (res_o.ready && !res_load) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_i.valid) begin
            cmd_q   <= stq_cmd_e'(cmd_i.command);
            tid_q   <= cmd_i.timer_id;
            exp_q   <= UptimeBits'(cmd_i.expires);
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (cmd_q)
            CMD_TICK: begin
              if (out_free) begin
                tick_q       <= tick_inc;
                processed_q  <= 1'b0;
                res_valid_q  <= 1'b1;
                res_fired_q  <= 1'b0;
                res_timer_q  <= '0;
                res_last_q   <= 1'b1;
                res_uptime_q <= UptimeOutW'(tick_inc);
                state_q      <= S_IDLE;
              end
            end
            CMD_ARM: begin
              state_q <= in_range ? S_APPEND : S_DONE;
            end
            CMD_DISARM: begin
              state_q <= S_DONE;
            end
            CMD_PROCESS: begin
              if (processed_q) begin
                state_q <= S_DONE;
              end else begin
                processed_q <= 1'b1;
                state_q     <= S_MERGE;
              end
            end
            default: begin
              state_q <= S_DONE;
            end
          endcase
        end
        S_APPEND: begin
          state_q <= S_DONE;
        end
        S_MERGE: begin
          if (!pend_tail.valid) begin
            state_q <= S_FIRE;
          end
        end
        S_FIRE: begin
          if (!head_fires) begin
            state_q <= S_DONE;
          end else if (out_free) begin
            res_valid_q  <= 1'b1;
            res_fired_q  <= 1'b1;
            res_timer_q  <= TimerIdW'(arm_head.id);
            res_last_q   <= !second_fires;
            res_uptime_q <= UptimeOutW'(tick_q);
            if (!second_fires) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            res_valid_q  <= 1'b1;
            res_fired_q  <= 1'b0;
            res_timer_q  <= '0;
            res_last_q   <= 1'b1;
            res_uptime_q <= UptimeOutW'(tick_q);
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // pending list in arm order
  stq_chain u_pend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (pend_ctrl),
    .head_o   (pend_head),
    .second_o (pend_second),
    .tail_o   (pend_tail)
  );

  // armed list sorted by expiry
  stq_chain u_arm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (arm_ctrl),
    .head_o   (arm_head),
    .second_o (arm_second),
    .tail_o   (arm_tail)
  );

endmodule

FILE: hw/rtl/stq_checker.sv
// port-level checks of the sorted timer queue, bound to the top level
`timescale 1ns / 1ps
module stq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic                           out_fired_i,
  input logic [stq_pkg::TimerIdW-1:0]   out_timer_i,
  input logic                           out_last_i,
  input logic [stq_pkg::UptimeOutW-1:0] out_uptime_i
);
  import stq_pkg::*;

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // a stalled word holds its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_fired_i)
      && $stable(out_timer_i) && $stable(out_last_i) && $stable(out_uptime_i))
    else $error("stalled result word changed");

  // a word without a fired slot closes its command and carries slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_fired_i |-> out_last_i && (out_timer_i == '0))
    else $error("empty result word not final");

  // one command at a time: busy right after taking a command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("command taken while previous one runs");

  // no command is taken in the middle of a burst of fired words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_last_i |-> !in_ready_i)
    else $error("command taken during fired burst");

endmodule

bind sorted_timer_queue_core stq_checker u_stq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (cmd_i.valid),
  .in_ready_i   (cmd_i.ready),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .out_fired_i  (res_o.fired_valid),
  .out_timer_i  (res_o.fired_timer),
  .out_last_i   (res_o.last),
  .out_uptime_i (res_o.uptime)
);
